// File: rtl/core/eiwc_pkg.sv
// Shared types and constants of the edge interval window capture block.
`timescale 1ns / 1ps

package eiwc_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = ADDR_W + 1;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned WINDOW_W    = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W     = QPTR_W + 1;

  localparam logic [WINDOW_W-1:0] WINDOW_LOW_RESET  = 32'd59882;
  localparam logic [WINDOW_W-1:0] WINDOW_HIGH_RESET = 32'd62306;

  typedef enum logic [1:0] {
    CMD_EDGE   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_WINDOW_LOW  = 1'b0,
    CFG_WINDOW_HIGH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              pin_level;
    logic [TIME_W-1:0] edge_time;
    logic [ADDR_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic               recorded;
    logic [COUNT_W-1:0] record_count;
    logic               entry_valid;
    logic               entry_level;
    logic [TIME_W-1:0]  entry_interval;
    logic               armed_now;
  } out_word_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    logic               write_en;
    logic [ADDR_W-1:0]  write_addr;
    logic               level;
    logic [TIME_W-1:0]  interval;
    logic               read_en;
    logic [ADDR_W-1:0]  read_addr;
    logic               recorded;
    logic [COUNT_W-1:0] record_count;
    logic               armed_now;
  } op_t;

endpackage

// File: rtl/core/eiwc_front.sv
// Front part: configuration registers, capture state and classification of each word.
`timescale 1ns / 1ps

module eiwc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  eiwc_pkg::in_word_t    item,
  input  logic                  queue_full,
  output logic                  item_stall,
  input  logic                  cfg_valid,
  input  eiwc_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  push,
  output eiwc_pkg::op_t         push_op
);

  logic [eiwc_pkg::WINDOW_W-1:0] window_low;
  logic [eiwc_pkg::WINDOW_W-1:0] window_high;
  logic                          armed;
  logic                          armed_next;
  logic                          seen_first;
  logic                          seen_first_next;
  logic [eiwc_pkg::TIME_W-1:0]   previous_time;
  logic [eiwc_pkg::TIME_W-1:0]   previous_time_next;
  logic [eiwc_pkg::COUNT_W-1:0]  count;
  logic [eiwc_pkg::COUNT_W-1:0]  count_next;
  logic [eiwc_pkg::TIME_W-1:0]   diff;
  logic                          outside;
  logic                          full;
  logic                          do_record;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  assign diff    = item.edge_time - previous_time;
  assign outside = (diff > {{(eiwc_pkg::TIME_W-eiwc_pkg::WINDOW_W){1'b0}}, window_high}) ||
                   (diff < {{(eiwc_pkg::TIME_W-eiwc_pkg::WINDOW_W){1'b0}}, window_low});
  assign full    = (count == eiwc_pkg::COUNT_W'(eiwc_pkg::STORE_DEPTH));
  assign do_record = (item.cmd == eiwc_pkg::CMD_EDGE) && armed && seen_first &&
                     outside && !full;

  always_comb begin
    armed_next         = armed;
    seen_first_next    = seen_first;
    previous_time_next = previous_time;
    count_next         = count;
    unique case (item.cmd)
      eiwc_pkg::CMD_EDGE: begin
        if (armed) begin
          seen_first_next    = 1'b1;
          previous_time_next = item.edge_time;
          if (do_record) begin
            count_next = count + 1'b1;
          end
        end
      end
      eiwc_pkg::CMD_ARM: begin
        if (!armed) begin
          count_next      = '0;
          seen_first_next = 1'b0;
          armed_next      = 1'b1;
        end
      end
      eiwc_pkg::CMD_DISARM: begin
        armed_next = 1'b0;
      end
      eiwc_pkg::CMD_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_op.write_en     = do_record;
    push_op.write_addr   = count[eiwc_pkg::ADDR_W-1:0];
    push_op.level        = item.pin_level;
    push_op.interval     = diff;
    push_op.read_en      = (item.cmd == eiwc_pkg::CMD_READ) &&
                           ({1'b0, item.read_index} < count);
    push_op.read_addr    = item.read_index;
    push_op.recorded     = do_record;
    push_op.record_count = count_next;
    push_op.armed_now    = armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= eiwc_pkg::WINDOW_LOW_RESET;
      window_high <= eiwc_pkg::WINDOW_HIGH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        eiwc_pkg::CFG_WINDOW_LOW:  window_low  <= cfg_data;
        eiwc_pkg::CFG_WINDOW_HIGH: window_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      seen_first    <= 1'b0;
      previous_time <= '0;
      count         <= '0;
    end else if (push) begin
      armed         <= armed_next;
      seen_first    <= seen_first_next;
      previous_time <= previous_time_next;
      count         <= count_next;
    end
  end

endmodule

// File: rtl/core/eiwc_queue.sv
// Short operation queue between the front and the back.
`timescale 1ns / 1ps

module eiwc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  eiwc_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output eiwc_pkg::op_t head
);

  eiwc_pkg::op_t                 slots [eiwc_pkg::QUEUE_DEPTH];
  logic [eiwc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [eiwc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [eiwc_pkg::QFILL_W-1:0]  fill;

  assign full      = (fill == eiwc_pkg::QFILL_W'(eiwc_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/core/eiwc_back.sv
// Back part: entry store access and the registered result stage.
`timescale 1ns / 1ps

module eiwc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                not_empty,
  input  eiwc_pkg::op_t       head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output eiwc_pkg::out_word_t result
);

  logic [eiwc_pkg::TIME_W:0] store [eiwc_pkg::STORE_DEPTH];
  logic [eiwc_pkg::TIME_W:0] rd_data;
  eiwc_pkg::op_t             held;
  logic                      held_valid;

  // A word leaves the queue whenever the result stage is empty or being taken.
  assign pop = not_empty && (!held_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (pop && head.write_en) begin
      store[head.write_addr] <= {head.level, head.interval};
    end
    if (pop && head.read_en) begin
      rd_data <= store[head.read_addr];
    end
    if (pop) begin
      held <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pop) begin
      held_valid <= 1'b1;
    end else if (!result_stall) begin
      held_valid <= 1'b0;
    end
  end

  assign result_valid = held_valid;

  always_comb begin
    result.recorded       = held.recorded;
    result.record_count   = held.record_count;
    result.entry_valid    = held.read_en;
    result.entry_level    = held.read_en & rd_data[eiwc_pkg::TIME_W];
    result.entry_interval = held.read_en ? rd_data[eiwc_pkg::TIME_W-1:0] : '0;
    result.armed_now      = held.armed_now;
  end

endmodule

// File: rtl/core/edge_interval_window_capture.sv
// Top level of the edge interval window capture block.
//
// The block measures the interval between successive pin edges while capture
// is armed and records intervals outside the normal window [window_low,
// window_high] in a store of 1024 entries, together with the pin level.
// Input words arrive on item/item_valid/item_stall: an edge event, an arm
// and clear, a disarm or a read of a stored entry. Every input word yields
// exactly one result word on result/result_valid/result_stall, in order.
// The two window registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, and writes belong to idle periods only.
// An accepted word goes through the queue into the registered result stage
// of the back, which shows its result word. One word is accepted every
// cycle while item_stall is low: the front classifies a word in the cycle
// it is taken (one 64-bit subtract and the window compares), the back does
// one store access per cycle on the single store port.
// A four-word queue sits between front and back. When the receiver stalls,
// the result word holds and the queue absorbs up to four further words before
// item_stall rises. Synchronous reset disarms capture, clears the count and
// restores the reset window; the store itself is not cleared, and only
// entries below the count are ever returned.
`timescale 1ns / 1ps

module edge_interval_window_capture (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  eiwc_pkg::in_word_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output eiwc_pkg::out_word_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  eiwc_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);

  logic          push;
  eiwc_pkg::op_t push_op;
  logic          queue_full;
  logic          pop;
  logic          not_empty;
  eiwc_pkg::op_t head;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  eiwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_op    (push_op)
  );

  eiwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  eiwc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/core/eiwc_checker.sv
// Port-level checks for the edge interval window capture block, with its bind.
`timescale 1ns / 1ps

module eiwc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input eiwc_pkg::in_word_t   item,
  input logic                 result_valid,
  input logic                 result_stall,
  input eiwc_pkg::out_word_t  result,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input eiwc_pkg::cfg_index_t cfg_index,
  input logic [31:0]          cfg_data
);

  // A stalled result word stays and does not change.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // Nothing leaves the block in the cycle after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown straight after reset");

  // An edge can only be recorded while capture is armed; such a result returns no entry and has a non-zero count.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.recorded |-> result.armed_now && !result.entry_valid &&
      result.record_count != '0)
    else $error("recorded edge without arm or count");

  // A valid entry lies below a non-zero count; an invalid one reads as zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.entry_valid |->
      !result.entry_level && result.entry_interval == '0)
    else $error("invalid entry carries data");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.entry_valid |-> result.record_count != '0)
    else $error("entry returned with empty store");

endmodule

bind edge_interval_window_capture eiwc_checker u_eiwc_checker (.*);
